### rtl/core/epid_pkg.sv
package epid_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int REG_IDX_W     = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_UNIT_PER_PULSE = 3'd0,
        REG_TARGET         = 3'd1,
        REG_GAIN_P         = 3'd2,
        REG_GAIN_I         = 3'd3,
        REG_GAIN_D         = 3'd4
    } reg_idx_t;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE  = 4'd0,
        OP_LOAD  = 4'd1,   // latch input, test skip, update count
        OP_POS   = 4'd2,   // position = count * unit
        OP_ERR   = 4'd3,   // error = target - position
        OP_IMUL  = 4'd4,   // err * elapsed
        OP_IDIV  = 4'd5,   // start divide by 1000
        OP_IACC  = 4'd6,   // accumulate integral
        OP_DMUL  = 4'd7,   // err * 1000; prev * 1000 is taken off at the divider input
        OP_DDIV  = 4'd8,   // start divide by elapsed
        OP_DSAT  = 4'd9,   // saturate derivative, save error as previous
        OP_PTERM = 4'd10,
        OP_ITRM1 = 4'd11,
        OP_ITRM2 = 4'd12,
        OP_DTERM = 4'd13,
        OP_OUT   = 4'd14,
        OP_SKIP  = 4'd15
    } op_t;

    typedef struct packed {
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic skip;
        logic div_done;
    } sts_t;

endpackage

### rtl/core/epid_div.sv
// signed restoring divider, one quotient bit per cycle, truncates toward zero
module epid_div
    import epid_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] dividend,
    input  logic        [31:0] divisor,
    output logic               done,
    output logic signed [63:0] quotient
);
    logic [63:0] q_reg, q_next;
    logic [63:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic        neg_reg, neg_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [64:0] trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {r_reg, q_reg[63]} - {33'd0, d_reg};
        if (start)
        begin
            q_next    = dividend[63] ? 64'(-dividend) : 64'(dividend);
            r_next    = '0;
            d_next    = divisor;
            neg_next  = dividend[63];
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[64])
            begin
                r_next = trial[63:0];
                q_next = {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[62:0], q_reg[63]};
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign done     = !busy_reg;
    assign quotient = neg_reg ? -$signed(q_reg) : $signed(q_reg);

`ifndef SYNTH
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> cnt_reg == 7'd0) else $error("divider count left over");
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg && cnt_reg == 7'd64) else $error("divider did not start");
    a_busy_len: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !start && cnt_reg > 7'd1 |=> busy_reg) else $error("divider ended early");
`endif
endmodule

// signed divide by 1000, sixteen dividend bits per cycle, truncates toward zero
module epid_div1k
    import epid_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] dividend,
    output logic               done,
    output logic signed [63:0] quotient
);
    // 2^36 / 1000 rounded up, exact for a partial dividend below 2^26
    localparam logic [26:0] RECIP   = 27'd68719477;
    localparam logic [9:0]  DIVISOR = 10'd1000;

    logic [63:0] x_reg, x_next;
    logic [63:0] q_reg, q_next;
    logic [9:0]  rem_reg, rem_next;
    logic        neg_reg, neg_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [25:0] part;
    logic [52:0] prod;
    logic [15:0] qd;
    logic [25:0] back;

    always_comb
    begin
        x_next    = x_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        // remainder so far joined with the next 16 dividend bits
        part      = {rem_reg, x_reg[63:48]};
        prod      = 53'(part) * 53'(RECIP);
        qd        = prod[51:36];
        back      = part - 26'(qd) * 26'(DIVISOR);
        if (start)
        begin
            x_next    = dividend[63] ? 64'(-dividend) : 64'(dividend);
            q_next    = '0;
            rem_next  = '0;
            neg_next  = dividend[63];
            cnt_next  = 3'd4;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            x_next   = {x_reg[47:0], 16'd0};
            q_next   = {q_reg[47:0], qd};
            rem_next = back[9:0];
            cnt_next = cnt_reg - 3'd1;
            if (cnt_reg == 3'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    assign done     = !busy_reg;
    assign quotient = neg_reg ? -$signed(q_reg) : $signed(q_reg);

`ifndef SYNTH
    a_k_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> cnt_reg == 3'd0) else $error("divide by 1000 count left over");
    a_k_start: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg && cnt_reg == 3'd4) else $error("divide by 1000 did not start");
    a_k_len: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !start && cnt_reg > 3'd1 |=> busy_reg)
        else $error("divide by 1000 ended early");
`endif
endmodule

### rtl/core/epid_dp.sv
module epid_dp
    import epid_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    input  logic [31:0]          now_ms,
    input  logic signed [15:0]   pulse_delta,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_idx,
    input  logic [31:0]          cfg_data,
    output logic                 updated,
    output logic signed [31:0]   drive,
    output logic signed [31:0]   position
);
    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;
    localparam logic signed [63:0] S48_MAX = 64'sd140737488355327;
    localparam logic signed [63:0] S48_MIN = -64'sd140737488355328;
    localparam logic signed [63:0] TERM_CAP = 64'sd1152921504606846976;
    localparam int SH = 24 - FRAC_BITS;
    localparam logic signed [63:0] LIM = TERM_CAP >>> SH;

    logic signed [31:0] unit_reg, target_reg, kp_reg, ki_reg, kd_reg;
    logic [31:0]        last_time_reg;
    logic signed [31:0] count_reg, prev_err_reg;
    logic signed [47:0] esum_reg;
    logic [31:0]        elapsed_reg;
    logic signed [31:0] pos_reg, err_reg, deriv_reg;
    logic signed [63:0] acc_reg, prod_reg;
    logic               skip_reg, upd_reg;
    logic signed [31:0] drive_reg, posout_reg;

    logic [31:0]        elapsed_c;
    logic signed [63:0] cnt_sum;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    logic               div_start, div_done;
    logic signed [63:0] div_q;
    logic               k_start, k_done;
    logic signed [63:0] k_q;
    logic signed [63:0] iterm_c;
    logic signed [47:0] ihi;
    logic signed [24:0] ilo;

    function automatic logic signed [63:0] sat(input logic signed [63:0] v,
        input logic signed [63:0] lo, input logic signed [63:0] hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    assign elapsed_c = now_ms - last_time_reg;
    assign cnt_sum   = 64'(count_reg) + 64'(pulse_delta);
    // integral split: hi = floor(sum / 2^24), lo in [0, 2^24)
    assign ihi       = esum_reg >>> 24;
    assign ilo       = {1'b0, esum_reg[23:0]};

    // shared 32x32 multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_POS:   begin mul_a = count_reg; mul_b = unit_reg; end
            OP_IMUL:  begin mul_a = err_reg;   mul_b = $signed(elapsed_reg); end
            OP_DMUL:  begin mul_a = err_reg;   mul_b = 32'sd1000; end
            OP_PTERM: begin mul_a = err_reg;   mul_b = kp_reg; end
            OP_ITRM1: begin mul_a = 32'(ihi);  mul_b = ki_reg; end
            OP_ITRM2: begin mul_a = 32'(ilo);  mul_b = ki_reg; end
            OP_DTERM: begin mul_a = deriv_reg; mul_b = kd_reg; end
            default:  begin mul_a = '0;        mul_b = '0; end
        endcase
    end
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    // upper integral term, scaled up and capped
    always_comb
    begin
        if (mul_p > LIM) iterm_c = TERM_CAP;
        else if (mul_p < -LIM) iterm_c = -TERM_CAP;
        else iterm_c = mul_p <<< SH;
    end

    assign div_start = cmd.op == OP_DDIV;
    assign k_start   = cmd.op == OP_IDIV;

    epid_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .dividend(prod_reg - 64'(prev_err_reg) * 64'sd1000),
        .divisor(elapsed_reg), .done(div_done), .quotient(div_q)
    );

    epid_div1k u_k (
        .clk(clk), .rst_n(rst_n), .start(k_start),
        .dividend(prod_reg), .done(k_done), .quotient(k_q)
    );

    assign sts.skip     = skip_reg;
    assign sts.div_done = div_done && k_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_reg <= '0; target_reg <= '0; kp_reg <= '0; ki_reg <= '0; kd_reg <= '0;
            last_time_reg <= '0; count_reg <= '0; esum_reg <= '0; prev_err_reg <= '0;
            skip_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    REG_UNIT_PER_PULSE: unit_reg   <= cfg_data;
                    REG_TARGET:         target_reg <= cfg_data;
                    REG_GAIN_P:         kp_reg     <= cfg_data;
                    REG_GAIN_I:         ki_reg     <= cfg_data;
                    REG_GAIN_D:         kd_reg     <= cfg_data;
                    default: ;
                endcase
            end
            case (cmd.op)
                OP_LOAD:
                begin
                    skip_reg <= $signed(elapsed_c) < 32'sd1 || pulse_delta == 16'sd0;
                    if (!($signed(elapsed_c) < 32'sd1 || pulse_delta == 16'sd0))
                    begin
                        last_time_reg <= now_ms;
                        count_reg     <= 32'(sat(cnt_sum, S32_MIN, S32_MAX));
                    end
                end
                OP_IACC:
                    esum_reg <= 48'(sat(64'(esum_reg) + k_q, S48_MIN, S48_MAX));
                OP_DSAT:
                    prev_err_reg <= err_reg;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:  elapsed_reg <= elapsed_c;
            OP_POS:   pos_reg <= 32'(sat(mul_p, S32_MIN, S32_MAX));
            OP_ERR:   err_reg <= 32'(sat(64'(target_reg) - 64'(pos_reg), S32_MIN, S32_MAX));
            OP_IMUL:  prod_reg <= mul_p;
            OP_DMUL:  prod_reg <= mul_p;
            OP_DSAT:  deriv_reg <= 32'(sat(div_q, S32_MIN, S32_MAX));
            OP_PTERM: acc_reg <= mul_p >>> FRAC_BITS;
            OP_ITRM1: acc_reg <= acc_reg + iterm_c;
            OP_ITRM2: acc_reg <= acc_reg + (mul_p >>> FRAC_BITS);
            OP_DTERM: acc_reg <= acc_reg + (mul_p >>> FRAC_BITS);
            OP_OUT:
            begin
                upd_reg    <= 1'b1;
                drive_reg  <= 32'(sat(acc_reg, S32_MIN, S32_MAX));
                posout_reg <= pos_reg;
            end
            OP_SKIP:
            begin
                upd_reg <= 1'b0; drive_reg <= '0; posout_reg <= '0;
            end
            default: ;
        endcase
    end

    assign updated  = upd_reg;
    assign drive    = drive_reg;
    assign position = posout_reg;
endmodule

### rtl/core/epid_ctrl.sv
module epid_ctrl
    import epid_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_fire,
    input  logic out_fire,
    input  sts_t sts,
    output cmd_t cmd,
    output logic in_rdy,
    output logic out_vld
);
    typedef enum logic [15:0] {
        S_IDLE  = 16'h0001, S_CHK   = 16'h0002, S_POS   = 16'h0004, S_ERR  = 16'h0008,
        S_IMUL  = 16'h0010, S_IDIV  = 16'h0020, S_IWAIT = 16'h0040, S_DMUL = 16'h0080,
        S_DDIV  = 16'h0100, S_DWAIT = 16'h0200, S_PT    = 16'h0400, S_IT1  = 16'h0800,
        S_IT2   = 16'h1000, S_DT    = 16'h2000, S_OUT   = 16'h4000, S_HOLD = 16'h8000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd.op       = OP_NONE;
        case (state_reg)
            S_IDLE:  if (in_fire) begin cmd.op = OP_LOAD; state_next = S_CHK; end
            S_CHK:
            begin
                if (sts.skip) begin cmd.op = OP_SKIP; state_next = S_HOLD; end
                else state_next = S_POS;
            end
            S_POS:   begin cmd.op = OP_POS;  state_next = S_ERR; end
            S_ERR:   begin cmd.op = OP_ERR;  state_next = S_IMUL; end
            S_IMUL:  begin cmd.op = OP_IMUL; state_next = S_IDIV; end
            S_IDIV:  begin cmd.op = OP_IDIV; state_next = S_IWAIT; end
            S_IWAIT:
            begin
                if (sts.div_done) begin cmd.op = OP_IACC; state_next = S_DMUL; end
            end
            S_DMUL:  begin cmd.op = OP_DMUL; state_next = S_DDIV; end
            S_DDIV:  begin cmd.op = OP_DDIV; state_next = S_DWAIT; end
            S_DWAIT:
            begin
                if (sts.div_done) begin cmd.op = OP_DSAT; state_next = S_PT; end
            end
            S_PT:    begin cmd.op = OP_PTERM; state_next = S_IT1; end
            S_IT1:   begin cmd.op = OP_ITRM1; state_next = S_IT2; end
            S_IT2:   begin cmd.op = OP_ITRM2; state_next = S_DT; end
            S_DT:    begin cmd.op = OP_DTERM; state_next = S_OUT; end
            S_OUT:   begin cmd.op = OP_OUT;   state_next = S_HOLD; end
            S_HOLD:  if (out_fire) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= S_IDLE;
        else        state_reg <= state_next;
    end

    assign in_rdy  = state_reg == S_IDLE;
    assign out_vld = state_reg == S_HOLD;

`ifndef SYNTH
    a_in_go: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == S_CHK) else $error("tick not taken");
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_rdy && out_vld)) else $error("ready while result pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld && !out_fire |=> out_vld) else $error("result dropped");
`endif
endmodule

### rtl/core/encoder_position_pid_top.sv
// encoder position pid loop
// s_axis carries one control tick per word: now_ms and pulse_delta.
// m_axis returns one word per tick: updated flag in tuser, drive and position
// in tdata. a skipped tick (elapsed under 1 ms or zero delta) returns
// updated 0 with zero drive and position and leaves the loop state alone.
// cfg writes gains, target and unit-per-pulse by index; write only when idle.
// when the loop runs, the time from an accepted tick to its result word is
// set mostly by the bit-serial divide by elapsed for the derivative; the
// integral divide by 1000 takes 16 bits per cycle; a skipped tick answers
// without running either divide.
// one tick is processed at a time; s_axis_tready returns the cycle after the
// result word is taken.
// a stalled receiver holds the result and the input side.
// reset clears registers, time, count, integral and previous error.
module encoder_position_pid_top
    import epid_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [47:0]          s_axis_tdata,   // now_ms[31:0], pulse_delta[47:32]
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [63:0]          m_axis_tdata,   // drive[31:0], position[63:32]
    output logic                 m_axis_tuser,   // updated
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);
    cmd_t cmd;
    sts_t sts;
    logic signed [31:0] drive, position;

    epid_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_fire(s_axis_tvalid && s_axis_tready),
        .out_fire(m_axis_tvalid && m_axis_tready),
        .sts(sts), .cmd(cmd), .in_rdy(s_axis_tready), .out_vld(m_axis_tvalid)
    );

    epid_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .now_ms(s_axis_tdata[31:0]), .pulse_delta(s_axis_tdata[47:32]),
        .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_data(cfg_data),
        .updated(m_axis_tuser), .drive(drive), .position(position)
    );

    assign cfg_ready    = 1'b1;
    assign m_axis_tdata = {position, drive};
endmodule

### verif/encoder_position_pid_checker.sv
`timescale 1ns / 1ps

// watches the tick, result and register channels, predicts each result word
// and compares it with what the block returns
module encoder_position_pid_checker
    import epid_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [47:0]          s_axis_tdata,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [63:0]          m_axis_tdata,
    input  logic                 m_axis_tuser,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    output int                   fail_count,
    output int                   pending
);

    localparam longint S32_MAX  = 64'sd2147483647;
    localparam longint S32_MIN  = -64'sd2147483648;
    localparam longint S48_MAX  = 64'sd140737488355327;
    localparam longint S48_MIN  = -64'sd140737488355328;
    localparam longint TERM_CAP = 64'sd1152921504606846976;

    typedef struct {
        logic        updated;
        logic [31:0] drive;
        logic [31:0] position;
    } result_t;

    result_t predicted_words[$];

    // register copies
    longint unit_q, target_q, kp_q, ki_q, kd_q;
    // loop state
    logic [31:0] last_ms;
    longint      count_q, integral_q, last_err_q;

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // ki times the 48-bit integral, split so the product stays in 64 bits
    function automatic longint integral_product();
        longint hi_part, lo_part, a, b, lim, scaled;
        hi_part = integral_q >>> 24;
        lo_part = integral_q - (hi_part <<< 24);
        a = ki_q * hi_part;
        b = ki_q * lo_part;
        lim = TERM_CAP >>> (24 - FRAC_BITS);
        if (a > lim)
            scaled = TERM_CAP;
        else if (a < -lim)
            scaled = -TERM_CAP;
        else
            scaled = a <<< (24 - FRAC_BITS);
        return scaled + (b >>> FRAC_BITS);
    endfunction

    function automatic result_t pid_tick(logic [31:0] now, logic signed [15:0] delta);
        result_t r;
        longint  elapsed, pos, err, deriv, drv;
        elapsed = longint'(signed'(now - last_ms));
        r.updated = 1'b0;
        r.drive = '0;
        r.position = '0;
        // skipped tick: time not advanced or no pulses
        if (elapsed < 1 || delta == 0)
            return r;
        last_ms = now;
        count_q = clamp(count_q + longint'(delta), S32_MIN, S32_MAX);
        pos = clamp(count_q * unit_q, S32_MIN, S32_MAX);
        err = clamp(target_q - pos, S32_MIN, S32_MAX);
        integral_q = clamp(integral_q + (err * elapsed) / 1000, S48_MIN, S48_MAX);
        deriv = clamp(((err - last_err_q) * 1000) / elapsed, S32_MIN, S32_MAX);
        last_err_q = err;
        drv = ((kp_q * err) >>> FRAC_BITS) + integral_product()
            + ((kd_q * deriv) >>> FRAC_BITS);
        drv = clamp(drv, S32_MIN, S32_MAX);
        r.updated = 1'b1;
        r.drive = drv[31:0];
        r.position = pos[31:0];
        return r;
    endfunction

    assign pending = predicted_words.size();

    always @(posedge clk or negedge rst_n)
    begin
        result_t got, want;
        longint  v;
        if (!rst_n)
        begin
            unit_q = 0; target_q = 0; kp_q = 0; ki_q = 0; kd_q = 0;
            last_ms = '0;
            count_q = 0; integral_q = 0; last_err_q = 0;
            fail_count = 0;
            predicted_words.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                v = longint'(signed'(cfg_data));
                case (cfg_index)
                    REG_UNIT_PER_PULSE: unit_q = v;
                    REG_TARGET:         target_q = v;
                    REG_GAIN_P:         kp_q = v;
                    REG_GAIN_I:         ki_q = v;
                    REG_GAIN_D:         kd_q = v;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                predicted_words.push_back(pid_tick(s_axis_tdata[31:0], s_axis_tdata[47:32]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.updated = m_axis_tuser;
                got.drive = m_axis_tdata[31:0];
                got.position = m_axis_tdata[63:32];
                if (predicted_words.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result word: updated %0b drive %h position %h",
                                 got.updated, got.drive, got.position);
                end
                else
                begin
                    want = predicted_words.pop_front();
                    if (got.updated !== want.updated || got.drive !== want.drive
                        || got.position !== want.position)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected upd %0b drv %h pos %h, got upd %0b drv %h pos %h",
                                     want.updated, want.drive, want.position,
                                     got.updated, got.drive, got.position);
                    end
                end
            end
        end
    end

endmodule

### verif/encoder_position_pid_top_tb.sv
`timescale 1ns / 1ps

module encoder_position_pid_top_tb;
    import epid_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [47:0]          s_axis_tdata = '0;    // now_ms[31:0], pulse_delta[47:32]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [63:0]          m_axis_tdata;         // drive[31:0], position[63:32]
    logic                 m_axis_tuser;         // updated
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [REG_IDX_W-1:0] cfg_index = REG_UNIT_PER_PULSE;
    logic [31:0]          cfg_data = '0;

    int          fail_count;
    int          pending;
    int          src_idle_pct = 0;
    int          snk_stall_pct = 0;
    int          quiet_cycles = 0;
    logic [31:0] last_ms = '0;    // timestamp of the last tick that should run the loop

    always #5 clk = ~clk;

    encoder_position_pid_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    encoder_position_pid_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // receiver back-pressure, rerolled every cycle
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);

    // watchdog: too long without any word moving on any channel
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_regs(logic [31:0] unit, logic [31:0] tgt, logic [31:0] kp,
                             logic [31:0] ki, logic [31:0] kd);
        write_reg(REG_UNIT_PER_PULSE, unit);
        write_reg(REG_TARGET, tgt);
        write_reg(REG_GAIN_P, kp);
        write_reg(REG_GAIN_I, ki);
        write_reg(REG_GAIN_D, kd);
    endtask

    // every tick answers, so an empty prediction queue means the block is idle
    task automatic wait_drained();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // one tick word; valid stays high into the next call unless a gap is rolled
    task automatic send_tick(logic [31:0] now, logic [15:0] delta);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {delta, now};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (signed'(now - last_ms) > 0 && delta != 16'd0)
            last_ms = now;
    endtask

    task automatic end_burst();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_reg();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
            2: return 32'($signed($urandom_range(0, 512)) - 256);
            default: return 32'($signed($urandom_range(0, 2 << 16)) - (1 << 16));
        endcase
    endfunction

    task automatic random_ticks(int n);
        int          pick;
        logic [31:0] now;
        logic [15:0] delta;
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 80)
            begin
                // well-formed tick with random content
                now = last_ms + $urandom_range(1, 40);
                if ($urandom_range(9) < 7)
                    delta = 16'($signed($urandom_range(0, 400)) - 200);
                else
                    delta = $urandom;
                if (delta == 16'd0)
                    delta = 16'd1;
            end
            else if (pick < 88)
            begin
                // time stood still or ran backward
                now = last_ms - $urandom_range(0, 5);
                delta = $urandom;
            end
            else if (pick < 94)
            begin
                now = last_ms + $urandom_range(1, 40);
                delta = '0;
            end
            else
            begin
                now = $urandom;
                delta = $urandom;
            end
            send_tick(now, delta);
        end
        end_burst();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: moderate gains, then skip cases and field extremes
        load_regs(32'h0001_0000, 32'h0064_0000, 32'h0001_0000, 32'h0000_1000,
                  32'h0000_0400);
        send_tick(32'd5, 16'd10);
        send_tick(32'd5, 16'd3);            // no time elapsed
        send_tick(32'd4, 16'd3);            // time went backward
        send_tick(32'd6, 16'd0);            // no pulses
        send_tick(32'd7, 16'h7FFF);
        send_tick(32'd8, 16'h8000);
        send_tick(32'd1008, 16'hFFFF);
        send_tick(32'hFFFF_FFFF, 16'd1);    // behind the last tick, skipped
        send_tick(32'h8000_03EF, 16'd1);    // largest forward step
        send_tick(32'hFFFF_FFFF, 16'd1);
        send_tick(32'd2, 16'd1);            // timestamp wraps
        end_burst();
        wait_drained();

        // register extremes
        load_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF);
        send_tick(32'd3, 16'h7FFF);
        send_tick(32'd4, 16'h8000);
        send_tick(32'd5000, 16'h8000);
        send_tick(32'd5001, 16'h7FFF);
        end_burst();
        wait_drained();
        load_regs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000);
        send_tick(32'd5002, 16'h7FFF);
        send_tick(32'd9000, 16'h8000);
        send_tick(32'd9001, 16'd1);
        send_tick(32'd9002, 16'hFFFF);
        end_burst();
        wait_drained();

        // random phases, idling mode rotates
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 45; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 45; end
                default: begin src_idle_pct = 21; snk_stall_pct = 21; end
            endcase
            if (ph == 7)
                load_regs(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
            else
                load_regs(rand_reg(), rand_reg(), rand_reg(), rand_reg(), rand_reg());
            random_ticks(152);
            wait_drained();
        end

        repeat (200) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
